// ===== design/temporal_median_depth_filter_assert.svh =====
// Assertion macros shared by the filter's RTL.
`ifndef TEMPORAL_MEDIAN_DEPTH_FILTER_ASSERT_SVH
`define TEMPORAL_MEDIAN_DEPTH_FILTER_ASSERT_SVH

// Checks an implication on every clock edge outside reset.
`define TMDF_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Checks an implication in the next cycle, outside reset.
`define TMDF_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== design/tmdf_pkg.sv =====
// ----------------------------------------------------------------------------
// tmdf_pkg
// Shared constants and types of the temporal median depth filter.
// ----------------------------------------------------------------------------
package tmdf_pkg;

  localparam int unsigned DepthW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 11;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_FRAME_WIDTH   = 2'd1,
    REG_FRAME_HEIGHT  = 2'd2
  } cfg_reg_t;

  typedef logic [DepthW-1:0] depth_t;

endpackage

// ===== design/tmdf_stream_if.sv =====
// ----------------------------------------------------------------------------
// tmdf_stream_if
// Valid/ready channel carrying one depth request or one filtered result.
// ----------------------------------------------------------------------------
interface tmdf_stream_if;
  logic            valid;
  logic            ready;
  tmdf_pkg::depth_t depth;
  logic            end_of_frame;

  modport source (output valid, output depth, output end_of_frame, input ready);
  modport sink   (input valid, input depth, input end_of_frame, output ready);
endinterface

// ===== design/temporal_median_depth_filter.sv =====
// ----------------------------------------------------------------------------
// temporal_median_depth_filter
// Per-pixel upper median of nonzero depth samples over recent frames, else the pixel.
// ----------------------------------------------------------------------------
// One depth request enters per clock while the output is not stalled, and one
// result leaves per request; the pipeline is four stages deep (address and
// frame bookkeeping, history read, sort, rank select).
// History lives in MAX_WINDOW frame memories, one per slot, each read at most
// once per cycle, and only the newest slot is written. Because a position is
// revisited only after a full frame, the read of stage two never collides with
// a pending write of the same position unless the frame is shorter than the
// pipeline; for such tiny frames a forwarding path compares slot and address
// of in-flight writes. Configuration writes clear the frame count; no clearing
// pass runs. The whole pipeline advances only when the output stage can move.
`include "temporal_median_depth_filter_assert.svh"

module temporal_median_depth_filter #(
  parameter int unsigned MAX_WINDOW = 8,
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tmdf_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tmdf_pkg::CfgDataW-1:0] cfg_data,
  tmdf_stream_if.sink                   depth_in,
  tmdf_stream_if.source                 depth_out
);

  localparam int unsigned SlotW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CntW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PixN  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW = $clog2(PixN);
  localparam int unsigned PosW  = $clog2(PixN + 1);
  localparam int unsigned XW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned DW    = tmdf_pkg::DepthW;

  // Configuration registers.
  logic [3:0]  window_length;
  logic [10:0] frame_width;
  logic [9:0]  frame_height;
  logic        cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index == tmdf_pkg::REG_WINDOW_LENGTH ||
                              cfg_index == tmdf_pkg::REG_FRAME_WIDTH ||
                              cfg_index == tmdf_pkg::REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= 4'd3;
      frame_width   <= 11'd640;
      frame_height  <= 10'd480;
    end else if (cfg_we) begin
      case (tmdf_pkg::cfg_reg_t'(cfg_index))
        tmdf_pkg::REG_WINDOW_LENGTH: window_length <= cfg_data[3:0];
        tmdf_pkg::REG_FRAME_WIDTH:   frame_width   <= cfg_data;
        tmdf_pkg::REG_FRAME_HEIGHT:  frame_height  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Effective (clamped) settings.
  logic [CntW-1:0] win;
  logic [XW-1:0]   w_eff;
  logic [YW-1:0]   h_eff;
  logic [PosW-1:0] total;

  always_comb begin
    if (window_length == 4'd0) win = CntW'(1);
    else if (32'(window_length) > MAX_WINDOW) win = CntW'(MAX_WINDOW);
    else win = CntW'(window_length);
    if (frame_width == 11'd0) w_eff = XW'(1);
    else if (32'(frame_width) > MAX_WIDTH) w_eff = XW'(MAX_WIDTH);
    else w_eff = XW'(frame_width);
    if (frame_height == 10'd0) h_eff = YW'(1);
    else if (32'(frame_height) > MAX_HEIGHT) h_eff = YW'(MAX_HEIGHT);
    else h_eff = YW'(frame_height);
  end

  // Frame size follows the registers directly, so the first request after a
  // configuration write already sees the new shape.
  assign total = PosW'(w_eff) * PosW'(h_eff);

  // Pipeline control: every stage moves when the output can move.
  logic adv;
  logic v1, v2, v3, v4;
  assign adv = !v4 || depth_out.ready;
  assign depth_in.ready = adv;

  logic take;
  assign take = depth_in.valid && adv;

  // Stage 1: frame bookkeeping.
  logic [PosW-1:0]  pos;
  logic [CntW-1:0]  held;
  logic [SlotW-1:0] newest;
  logic [CntW-1:0]  held_next;
  logic [SlotW-1:0] newest_next;
  logic [PosW-1:0]  pos_cur;
  logic             last;

  always_comb begin
    pos_cur     = (pos >= total) ? '0 : pos;
    held_next   = (held > win) ? win : held;
    newest_next = (CntW'(newest) >= win) ? '0 : newest;
    if (pos_cur == '0) begin
      if (held_next == '0) newest_next = '0;
      else if (CntW'(newest_next) + CntW'(1) >= win) newest_next = '0;
      else newest_next = newest_next + SlotW'(1);
      if (held_next < win) held_next = held_next + CntW'(1);
    end
    last = (pos_cur + PosW'(1) == total);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      pos    <= '0;
      held   <= '0;
      newest <= '0;
    end else if (take) begin
      pos    <= last ? '0 : pos_cur + PosW'(1);
      held   <= held_next;
      newest <= newest_next;
    end
  end

  // Stage 1 registers.
  logic [AddrW-1:0] a1;
  logic [SlotW-1:0] s1;
  logic [CntW-1:0]  h1, w1c;
  logic [DW-1:0]    p1;
  logic             e1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= take;
    if (adv) begin
      a1 <= AddrW'(pos_cur);
      s1 <= newest_next;
      h1 <= held_next;
      w1c <= win;
      p1 <= depth_in.depth;
      e1 <= last;
    end
  end

  // Per-slot relative age: slot k holds the frame that is (s1 - k) modulo the window steps old.
  // A slot is used when its age is below the frames held.
  logic [MAX_WINDOW-1:0] use1;
  always_comb begin
    for (int k = 0; k < MAX_WINDOW; k++) begin
      logic [CntW:0] age;
      age = (k <= int'(s1)) ? (CntW+1)'(int'(s1) - k)
                            : (CntW+1)'(int'(s1) + int'(w1c) - k);
      use1[k] = (k < int'(w1c)) && (age < (CntW+1)'(h1));
    end
  end

  // Stage 2: history memories, one per slot; the newest slot takes the
  // incoming pixel directly.
  logic [DW-1:0] rd2 [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] use2;
  logic [SlotW-1:0] s2;
  logic [AddrW-1:0] a2;
  logic [DW-1:0]    p2;
  logic [CntW-1:0]  h2;
  logic             e2;

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_bank
    logic [DW-1:0] mem [PixN];
    always_ff @(posedge clk) begin
      if (adv && v1) begin
        if (s1 == SlotW'(g)) mem[a1] <= p1;
        rd2[g] <= mem[a1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      use2 <= use1;
      s2 <= s1;
      a2 <= a1;
      p2 <= p1;
      h2 <= h1;
      e2 <= e1;
    end
  end

  // Forwarding for frames shorter than the pipeline: a write in flight to
  // the same address and slot supersedes the memory read.
  logic [AddrW-1:0] a3;
  logic [SlotW-1:0] s3;
  logic [DW-1:0]    p3;
  logic [AddrW-1:0] a4;
  logic [SlotW-1:0] s4;
  logic [DW-1:0]    p4w;

  logic [DW-1:0] samp [MAX_WINDOW];
  always_comb begin
    for (int k = 0; k < MAX_WINDOW; k++) begin
      if (SlotW'(k) == s2) samp[k] = p2;
      else if (v3 && a3 == a2 && s3 == SlotW'(k)) samp[k] = p3;
      else if (v4 && a4 == a2 && s4 == SlotW'(k)) samp[k] = p4w;
      else samp[k] = rd2[k];
      if (!use2[k]) samp[k] = '0;
    end
  end

  // Stage 3: rank of each sample among nonzero samples (ties by slot).
  logic [CntW-1:0] rank [MAX_WINDOW];
  logic [CntW-1:0] cnt2;
  always_comb begin
    cnt2 = '0;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      rank[k] = '0;
      if (samp[k] != '0) cnt2 = cnt2 + CntW'(1);
      for (int j = 0; j < MAX_WINDOW; j++) begin
        if (samp[j] != '0 && samp[k] != '0 &&
            (samp[j] < samp[k] || (samp[j] == samp[k] && j < k)))
          rank[k] = rank[k] + CntW'(1);
      end
    end
  end

  logic [DW-1:0]   v3s [MAX_WINDOW];
  logic [CntW-1:0] r3 [MAX_WINDOW];
  logic [CntW-1:0] cnt3, h3;
  logic            e3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      v3s <= samp;
      r3 <= rank;
      cnt3 <= cnt2;
      h3 <= h2;
      a3 <= a2;
      s3 <= s2;
      p3 <= p2;
      e3 <= e2;
    end
  end

  // Stage 4: pick the upper median.
  logic [DW-1:0] med;
  always_comb begin
    med = p3;
    if (h3 >= CntW'(2) && cnt3 != '0) begin
      for (int k = 0; k < MAX_WINDOW; k++)
        if (v3s[k] != '0 && r3[k] == (cnt3 >> 1)) med = v3s[k];
    end
  end

  logic [DW-1:0] out_d;
  logic          out_e;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
    if (adv) begin
      out_d <= med;
      out_e <= e3;
      a4 <= a3;
      s4 <= s3;
      p4w <= p3;
    end
  end

  assign depth_out.valid = v4;
  assign depth_out.depth = out_d;
  assign depth_out.end_of_frame = out_e;

  `TMDF_ASSERT_NEXT(a_stall_hold, clk, rst, v4 && !depth_out.ready,
    v4 && $stable(out_d), "result changed under stall")
  `TMDF_ASSERT_IMPL(a_held_range, clk, rst, 1'b1, held <= CntW'(MAX_WINDOW),
    "frame count beyond window")
  `TMDF_ASSERT_IMPL(a_count_bound, clk, rst, v3, cnt3 <= h3,
    "more samples than frames held")

endmodule

// ===== sim/tmdf_median_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tmdf_median_checker
// Watches the filter's depth channels and configuration port, predicts each
// filtered pixel from its own copy of the frame history and compares.
// ----------------------------------------------------------------------------
module tmdf_median_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tmdf_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tmdf_pkg::CfgDataW-1:0] cfg_data,
  tmdf_stream_if                        pix_ch,
  tmdf_stream_if                        filt_ch,
  output int                            mismatches,
  output int                            outstanding
);

  localparam int unsigned WinMax = 8;
  localparam int unsigned WidthMax = 1024;
  localparam int unsigned HeightMax = 512;
  localparam int unsigned FramePixels = WidthMax * HeightMax;
  localparam int unsigned PredDepth = 16;

  typedef struct packed {
    tmdf_pkg::depth_t depth;
    logic             eof;
  } filtered_pixel_t;

  filtered_pixel_t  pred_fifo[PredDepth];
  int unsigned      pred_wr;
  int unsigned      pred_rd;
  tmdf_pkg::depth_t history[int unsigned];
  logic [3:0]       win_reg;
  logic [10:0]      width_reg;
  logic [9:0]       height_reg;
  int unsigned      position;
  int unsigned      held;
  int unsigned      newest;

  function automatic int unsigned clamp1(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Stores the pixel in the ring and returns the upper median of the nonzero samples
  // at this position, or the pixel itself when there are none or under two frames held.
  function automatic filtered_pixel_t filter_pixel(tmdf_pkg::depth_t pix);
    int unsigned      win, total, cnt, slot, j;
    tmdf_pkg::depth_t vals[WinMax];
    tmdf_pkg::depth_t v;
    filtered_pixel_t  res;
    win = clamp1(win_reg, WinMax);
    total = clamp1(width_reg, WidthMax) * clamp1(height_reg, HeightMax);
    cnt = 0;
    res.depth = pix;
    if (position >= total) position = 0;
    if (held > win) held = win;
    if (newest >= win) newest = 0;
    if (position == 0) begin
      newest = (held == 0) ? 0 : (newest + 1) % win;
      if (held < win) held++;
    end
    history[newest * FramePixels + position] = pix;
    if (held >= 2) begin
      for (int i = 0; i < held; i++) begin
        slot = (newest + win - i) % win;
        v = history[slot * FramePixels + position];
        if (v != 0) begin
          j = cnt;
          while (j > 0 && vals[j-1] > v) begin
            vals[j] = vals[j-1];
            j--;
          end
          vals[j] = v;
          cnt++;
        end
      end
      if (cnt > 0) res.depth = vals[cnt/2];
    end
    res.eof = (position + 1 == total);
    position = res.eof ? 0 : position + 1;
    return res;
  endfunction

  assign outstanding = int'(pred_wr - pred_rd);

  always @(posedge clk) begin
    filtered_pixel_t want;
    if (rst) begin
      win_reg <= 4'd3;
      width_reg <= 11'd640;
      height_reg <= 10'd480;
      position = 0;
      held = 0;
      newest = 0;
      mismatches <= 0;
      pred_wr = 0;
      pred_rd = 0;
    end else begin
      if (cfg_we && cfg_index <= tmdf_pkg::REG_FRAME_HEIGHT) begin
        case (tmdf_pkg::cfg_reg_t'(cfg_index))
          tmdf_pkg::REG_WINDOW_LENGTH: win_reg <= cfg_data[3:0];
          tmdf_pkg::REG_FRAME_WIDTH:   width_reg <= cfg_data;
          default:                     height_reg <= cfg_data[9:0];
        endcase
        position = 0;
        held = 0;
        newest = 0;
      end
      if (filt_ch.valid && filt_ch.ready) begin
        if (pred_wr == pred_rd) begin
          if (mismatches < 10) $display("unexpected result depth=%h eof=%b",
                                        filt_ch.depth, filt_ch.end_of_frame);
          mismatches <= mismatches + 1;
        end else begin
          want = pred_fifo[pred_rd % PredDepth];
          pred_rd++;
          if (want.depth !== filt_ch.depth || want.eof !== filt_ch.end_of_frame) begin
            if (mismatches < 10)
              $display("mismatch: expected depth=%h eof=%b, got depth=%h eof=%b",
                       want.depth, want.eof, filt_ch.depth, filt_ch.end_of_frame);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (pix_ch.valid && pix_ch.ready) begin
        pred_fifo[pred_wr % PredDepth] = filter_pixel(pix_ch.depth);
        pred_wr++;
      end
    end
  end
endmodule

// ===== sim/tb_temporal_median_depth_filter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_temporal_median_depth_filter
// Drives depth frames through the temporal median filter under random
// back-pressure and idle gaps, across several window and frame settings.
// ----------------------------------------------------------------------------
module tb_temporal_median_depth_filter;

  // Index past the register list; a write there must leave the state alone.
  localparam logic [tmdf_pkg::CfgIdxW-1:0] RegBeyondList = 2'd3;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [tmdf_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [tmdf_pkg::CfgDataW-1:0] cfg_data = '0;
  int                            mismatches;
  int                            outstanding;
  bit                            steady_ready = 1'b0;
  tmdf_pkg::depth_t              scene[64];
  int unsigned                   scene_pos;

  tmdf_stream_if pix_ch ();
  tmdf_stream_if filt_ch ();

  initial begin
    pix_ch.valid = 1'b0;
    pix_ch.depth = '0;
    pix_ch.end_of_frame = 1'b0;
    filt_ch.ready = 1'b0;
  end

  always #5 clk = ~clk;

  temporal_median_depth_filter i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .depth_in  (pix_ch),
    .depth_out (filt_ch)
  );

  tmdf_median_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pix_ch      (pix_ch),
    .filt_ch     (filt_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Returns a gap length: mostly none or short, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The result side stalls at random, except during stretches in which the
  // sender toggles steady_ready to keep the output flowing.
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (steady_ready) begin
        filt_ch.ready <= 1'b1;
      end else if (stall > 0) begin
        filt_ch.ready <= 1'b0;
        stall--;
      end else begin
        stall = gap_len();
        filt_ch.ready <= (stall == 0);
      end
    end
  end

  // Sends one depth request, after an optional idle gap, and holds it until
  // the filter accepts it.
  task automatic send_pixel(tmdf_pkg::depth_t pix, bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : gap_len();
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.depth <= pix;
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  // Configuration is written only when the filter is drained: all results
  // back and a few cycles beyond the four-stage pipeline.
  task automatic write_reg(logic [tmdf_pkg::CfgIdxW-1:0] idx,
                           logic [tmdf_pkg::CfgDataW-1:0] val);
    pix_ch.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_shape(logic [3:0] win, logic [10:0] width, logic [9:0] height);
    write_reg(tmdf_pkg::REG_WINDOW_LENGTH, tmdf_pkg::CfgDataW'(win));
    write_reg(tmdf_pkg::REG_FRAME_WIDTH, width);
    write_reg(tmdf_pkg::REG_FRAME_HEIGHT, tmdf_pkg::CfgDataW'(height));
  endtask

  // A pixel that often follows a fixed random scene with small noise, with invalid zeros,
  // extremes and fully random outliers mixed in.
  function automatic tmdf_pkg::depth_t scene_pixel();
    int unsigned r;
    tmdf_pkg::depth_t base;
    base = scene[scene_pos % 64];
    scene_pos++;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 24) return '1;
    if (r < 27) return 16'd1;
    if (r < 75) return base + tmdf_pkg::depth_t'($urandom_range(0, 15)) -
                       tmdf_pkg::depth_t'(8);
    return tmdf_pkg::depth_t'($urandom());
  endfunction

  task automatic send_frames(int unsigned pixels_per_frame, int unsigned frames);
    bit burst;
    foreach (scene[k]) scene[k] = tmdf_pkg::depth_t'($urandom());
    for (int f = 0; f < frames; f++) begin
      scene_pos = 0;
      burst = ($urandom_range(0, 4) == 0);
      steady_ready <= burst;
      for (int p = 0; p < pixels_per_frame; p++) send_pixel(scene_pixel(), burst);
    end
    steady_ready <= 1'b0;
  endtask

  initial begin
    tmdf_pkg::depth_t directed[20];
    int unsigned w, h;
    directed = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'h0000,
                 16'h1234, 16'h0000, 16'hFFFF, 16'h0002, 16'h0000, 16'h0000,
                 16'hAAAA, 16'h5555, 16'h0000, 16'h0001, 16'hFFFE, 16'h0000,
                 16'h0000, 16'h4000};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset shape: a single partial frame, so every pixel passes through.
    foreach (directed[k]) send_pixel(directed[k], 1'b0);

    // Two by two frames over a three-frame window: medians of two and three
    // samples, all-zero positions and zeros mixed with extremes.
    set_shape(4'd3, 11'd2, 10'd2);
    foreach (directed[k]) send_pixel(directed[k], 1'b0);

    // Window of zero acts as one and height of zero acts as one.
    set_shape(4'd0, 11'd4, 10'd0);
    send_frames(4, 6);

    // A window beyond the maximum saturates to eight frames.
    set_shape(4'd15, 11'd3, 10'd1);
    send_frames(3, 14);

    // Height beyond the maximum saturates, one-pixel-wide frames of 512 rows.
    set_shape(4'd8, 11'd0, 10'd1023);
    send_frames(512, 1);

    // A write beyond the register list must leave the history intact.
    set_shape(4'd4, 11'd5, 10'd2);
    send_frames(10, 3);
    write_reg(RegBeyondList, '1);
    send_frames(10, 3);

    // Random shapes, small frames so many frames fill the window.
    repeat (9) begin
      w = $urandom_range(0, 9);
      h = $urandom_range(0, 4);
      set_shape(4'($urandom_range(0, 15)), 11'(w), 10'(h));
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      send_frames(w * h, $urandom_range(3, 12));
    end

    pix_ch.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
